// ===== hw/rtl/bclv_pkg.sv =====
package bclv_pkg;

	// Walk phases over one program line
	typedef enum logic [2:0] {
		PH_LINK_LO = 3'd0,
		PH_LINK_HI = 3'd1,
		PH_NUM_LO  = 3'd2,
		PH_NUM_HI  = 3'd3,
		PH_TOKENS  = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	// Result word kinds, carried on tuser
	typedef enum logic [1:0] {
		EV_REPAIR = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_REJECT = 2'd2
	} event_kind_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LOAD_ADDRESS    = 2'd0;
	localparam cfg_idx_t CFG_MEMORY_TOP      = 2'd1;
	localparam cfg_idx_t CFG_MAX_LINE_NUMBER = 2'd2;
	localparam cfg_idx_t CFG_REPAIR_ENABLE   = 2'd3;

	// Register reset values
	localparam logic [15:0] LOAD_ADDRESS_RST    = 16'h0801;
	localparam logic [15:0] MEMORY_TOP_RST      = 16'hC000;
	localparam logic [15:0] MAX_LINE_NUMBER_RST = 16'd63999;

	// Result word payload, highest field first
	typedef struct packed {
		logic [15:0] program_length;
		logic [15:0] link_value;
		logic [15:0] link_offset;
	} result_t;

endpackage

// ===== hw/rtl/basic_line_chain_validator_top.sv =====
// Channel  | Direction | Signals                          | Word
// ---------+-----------+----------------------------------+------------------------------------
// s        | in        | s_tvalid s_tready s_tdata s_tlast | one image byte, tlast on final byte
// m        | out       | m_tvalid m_tready m_tdata m_tuser | repair / accept / reject event
// cfg      | in        | cfg_valid cfg_ready cfg_index     | register write, cfg_ready always high
//          |           | cfg_data                          |
//
// Each byte passes through the input register and then the walk logic into the
// result register; one byte per cycle sustained unless an event stall holds it.
// The line walk state updates when the input register hands its byte on.
// The result register stalls the walk only when a byte yields an event and the
// previous event is still unclaimed. arst_n clears the walk, both valid flags and
// restores register defaults.
module basic_line_chain_validator_top (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic                   s_tlast,   // last_byte
	// Result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [47:0]            m_tdata,   // [15:0] link_offset, [31:16] link_value,
	                                          // [47:32] program_length
	output logic [1:0]             m_tuser,   // [1:0] event_kind
	// Configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  bclv_pkg::cfg_idx_t     cfg_index,
	input  logic [15:0]            cfg_data
);
	import bclv_pkg::*;

	// Configuration registers
	logic [15:0] load_address_q;
	logic [15:0] memory_top_q;
	logic [15:0] max_line_number_q;
	logic        repair_enable_q;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Walk state
	phase_t      phase_q;
	phase_t      phase_next;
	logic [15:0] pos_q;
	logic [15:0] line_start_q;
	logic [15:0] landing_q;
	logic [15:0] prev_line_q;
	logic [7:0]  held_lo_q;
	logic        link_nz_q;

	// Result register
	logic        out_valid_q;
	event_kind_t out_kind_q;
	result_t     out_data_q;

	// Walk logic
	logic        fire;
	event_kind_t res_kind;
	logic [15:0] res_len;
	logic [15:0] landing_eff;
	logic [15:0] line_num;
	logic [15:0] line_len;
	logic [15:0] next_link;
	logic [15:0] pos_inc;
	logic        adv_s1;

	assign cfg_ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_address_q    <= LOAD_ADDRESS_RST;
			memory_top_q      <= MEMORY_TOP_RST;
			max_line_number_q <= MAX_LINE_NUMBER_RST;
			repair_enable_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOAD_ADDRESS:    load_address_q    <= cfg_data;
				CFG_MEMORY_TOP:      memory_top_q      <= cfg_data;
				CFG_MAX_LINE_NUMBER: max_line_number_q <= cfg_data;
				CFG_REPAIR_ENABLE:   repair_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Shared arithmetic
	assign pos_inc     = pos_q + 16'd1;
	assign landing_eff = (phase_q == PH_LINK_LO && pos_q == 16'd0) ? load_address_q : landing_q;
	assign line_num    = {byte_s1, held_lo_q};
	assign line_len    = pos_inc - line_start_q;
	assign next_link   = landing_eff + line_len;

	// Next phase
	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			PH_LINK_LO: phase_next = last_s1 ? PH_DONE : PH_LINK_HI;
			PH_LINK_HI: begin
				if ((!link_nz_q && byte_s1 == 8'd0) || last_s1)
					phase_next = PH_DONE;
				else
					phase_next = PH_NUM_LO;
			end
			PH_NUM_LO: phase_next = last_s1 ? PH_DONE : PH_NUM_HI;
			PH_NUM_HI: begin
				if (line_num > max_line_number_q || line_num < prev_line_q || last_s1)
					phase_next = PH_DONE;
				else
					phase_next = PH_TOKENS;
			end
			PH_TOKENS: begin
				if (byte_s1 == 8'd0) begin
					if (next_link <= landing_eff || next_link >= memory_top_q || last_s1)
						phase_next = PH_DONE;
					else
						phase_next = PH_LINK_LO;
				end else if (last_s1) begin
					phase_next = PH_DONE;
				end
			end
			default: phase_next = PH_DONE;
		endcase
	end

	// Event decode
	always_comb begin
		fire     = 1'b0;
		res_kind = EV_REJECT;
		res_len  = 16'd0;
		unique case (phase_q)
			PH_LINK_LO, PH_NUM_LO: fire = last_s1;
			PH_LINK_HI: begin
				if (!link_nz_q && byte_s1 == 8'd0) begin
					fire     = 1'b1;
					res_kind = EV_ACCEPT;
					res_len  = pos_inc;
				end else begin
					fire = last_s1;
				end
			end
			PH_NUM_HI: fire = (phase_next == PH_DONE);
			PH_TOKENS: begin
				if (phase_next == PH_DONE) begin
					fire = 1'b1;
				end else if (phase_next == PH_LINK_LO) begin
					fire     = repair_enable_q;
					res_kind = EV_REPAIR;
				end
			end
			default: fire = 1'b0;
		endcase
	end

	// Hand the byte on unless its event would overrun an unclaimed one
	assign adv_s1   = valid_s1 && (!fire || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Advance the walk; restart it after a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LINK_LO;
			pos_q        <= 16'd0;
			line_start_q <= 16'd0;
			landing_q    <= LOAD_ADDRESS_RST;
			prev_line_q  <= 16'd0;
			held_lo_q    <= 8'd0;
			link_nz_q    <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				phase_q      <= PH_LINK_LO;
				pos_q        <= 16'd0;
				line_start_q <= 16'd0;
				landing_q    <= load_address_q;
				prev_line_q  <= 16'd0;
				held_lo_q    <= 8'd0;
				link_nz_q    <= 1'b0;
			end else begin
				phase_q   <= phase_next;
				pos_q     <= pos_inc;
				// A good line moves the landing address on to its recomputed link
				landing_q <= (phase_q == PH_TOKENS && phase_next == PH_LINK_LO) ?
					next_link : landing_eff;
				if (phase_q == PH_LINK_LO) begin
					line_start_q <= pos_q;
					link_nz_q    <= (byte_s1 != 8'd0);
				end
				if (phase_q == PH_NUM_LO)
					held_lo_q <= byte_s1;
				if (phase_q == PH_NUM_HI && phase_next == PH_TOKENS)
					prev_line_q <= line_num;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && fire)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && fire) begin
			out_kind_q                <= res_kind;
			out_data_q.program_length <= res_len;
			out_data_q.link_offset    <= (res_kind == EV_REPAIR) ? line_start_q : 16'd0;
			out_data_q.link_value     <= (res_kind == EV_REPAIR) ? next_link : 16'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	// A held byte is never lost while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register dropped a stalled byte");

	// A final byte always restarts the walk
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> phase_q == PH_LINK_LO && pos_q == 16'd0)
		else $error("walk did not restart after final byte");

	// Repair events only while repair is on
	a_repair_en: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && fire && res_kind == EV_REPAIR |-> repair_enable_q)
		else $error("repair event with repair disabled");

	// A repaired link is nonzero and below the memory top
	a_link_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_REPAIR |->
			m_tdata[31:16] != 16'd0 && m_tdata[31:16] < memory_top_q)
		else $error("repaired link out of range");

endmodule
